>>> design/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants for the best-fit block allocator: stream field widths,
// result status codes and the fixed header overhead added to each request.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // stream field widths
    localparam int REQ_W = 16;
    localparam int OFS_W = 12;
    localparam int IN_W  = 16;
    localparam int OUT_W = 16;
    localparam int PAD_W = OUT_W - 1 - OFS_W;

    // bytes added to every request before rounding
    localparam int HEADER_ADD = 8;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

endpackage

>>> design/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Single-port synchronous RAM, one read or write per cycle, registered read.
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/best_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit allocator over an implicit list of block headers held in a RAM.
// ----------------------------------------------------------------------------
// One request is handled at a time. After reset the block writes the initial
// heap header in S_INIT before it takes its first item. The request is
// rounded up to whole granules by an adder and a shift in the accept cycle,
// so ALIGN_BYTES must be a power of two. The walk then visits S_WRD (RAM
// read) and S_WEV (evaluate) for each block header, since the single RAM
// port has a registered read, and S_WRD sees the heap end. If a block was
// found, S_SPL1 writes the chosen header and either S_SPL2 writes the split
// remainder or S_NRD and S_NWR update the successor's previous-in-use mark;
// S_FIN then loads the result. A zero-size request goes from the accept
// straight to S_FIN. A result waits in its output register while the next
// item is accepted; a new result is held back only while one is still
// waiting to be taken.
// ----------------------------------------------------------------------------
module best_fit_block_allocator #(
    parameter int HEAP_BYTES   = 4096,
    parameter int ALIGN_BYTES  = 16,
    parameter int HEADER_BYTES = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [bfa_pkg::IN_W-1:0] i_s_tdata,   // [15:0] request_bytes
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [bfa_pkg::OUT_W-1:0] o_m_tdata   // [0] status, [12:1] payload_offset
);
    import bfa_pkg::*;

    // heap geometry
    localparam int NGRAN = HEAP_BYTES / ALIGN_BYTES;
    localparam int AW    = $clog2(NGRAN);
    localparam int SZW   = $clog2(NGRAN + 1);
    localparam int HW    = SZW + 2;
    // round-up widths
    localparam int XW    = $clog2((1 << REQ_W) + HEADER_ADD + ALIGN_BYTES);
    localparam int RW    = $clog2(ALIGN_BYTES);
    localparam int CW    = (XW > SZW) ? XW : SZW;

    localparam logic [SZW-1:0] NGRAN_V = SZW'(NGRAN);
    localparam logic [XW-1:0]  ROUND_V = XW'(HEADER_ADD + ALIGN_BYTES - 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_WRD, S_WEV, S_SPL1, S_SPL2, S_NRD, S_NWR, S_FIN
    } t_state;

    // header layout: {size, busy, previous block in use}
    t_state            r_state, n_state;
    logic [CW-1:0]     r_need, n_need;
    logic [SZW-1:0]    r_pos, n_pos;
    logic [SZW-1:0]    r_best_pos, n_best_pos;
    logic [SZW-1:0]    r_best_sz, n_best_sz;
    logic              r_best_prev, n_best_prev;
    logic              r_found, n_found;
    logic              r_status, n_status;
    logic              r_out_valid, n_out_valid;
    logic              r_out_status, n_out_status;
    logic [OFS_W-1:0]  r_out_ofs, n_out_ofs;

    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [HW-1:0]     mem_wdata;
    logic [HW-1:0]     mem_rdata;

    // round-up and walk helpers
    logic [XW-1:0]     req_sum;
    logic [SZW-1:0]    rd_sz;
    logic              rd_busy;
    logic              rd_prev;
    logic [SZW-1:0]    need_sz;
    logic [SZW-1:0]    rem_pos;
    logic [SZW-1:0]    nxt_pos;
    logic [31:0]       ofs_full;

    assign req_sum  = XW'(i_s_tdata[REQ_W-1:0]) + ROUND_V;
    assign rd_sz    = mem_rdata[HW-1:2];
    assign rd_busy  = mem_rdata[1];
    assign rd_prev  = mem_rdata[0];
    assign need_sz  = r_need[SZW-1:0];
    assign rem_pos  = r_best_pos + need_sz;
    assign nxt_pos  = r_best_pos + r_best_sz;
    assign ofs_full = 32'(r_best_pos) * 32'(ALIGN_BYTES) + 32'(HEADER_BYTES);

    bfa_ram #(
        .WIDTH (HW),
        .DEPTH (NGRAN)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // sequencer next-state and RAM port
    always_comb begin
        n_state      = r_state;
        n_need       = r_need;
        n_pos        = r_pos;
        n_best_pos   = r_best_pos;
        n_best_sz    = r_best_sz;
        n_best_prev  = r_best_prev;
        n_found      = r_found;
        n_status     = r_status;
        n_out_status = r_out_status;
        n_out_ofs    = r_out_ofs;
        n_out_valid  = r_out_valid & ~i_m_tready;
        mem_we       = 1'b0;
        mem_addr     = r_pos[AW-1:0];
        mem_wdata    = '0;

        case (r_state)
            // one free block spanning the heap; other entries are never read
            S_INIT: begin
                mem_we    = 1'b1;
                mem_addr  = '0;
                mem_wdata = {NGRAN_V, 1'b0, 1'b1};
                n_state   = S_IDLE;
            end
            // take an item; header added and rounded up to whole granules
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_status = STATUS_FAIL;
                    n_need   = CW'(req_sum[XW-1:RW]);
                    n_pos    = '0;
                    n_found  = 1'b0;
                    n_state  = (i_s_tdata[REQ_W-1:0] == '0) ? S_FIN : S_WRD;
                end
            end
            S_WRD: begin
                if (r_pos >= NGRAN_V) begin
                    n_state = r_found ? S_SPL1 : S_FIN;
                end else begin
                    n_state = S_WEV;
                end
            end
            // evaluate one header; a corrupt header ends the walk
            S_WEV: begin
                if (rd_sz == '0 || rd_sz > (NGRAN_V - r_pos)) begin
                    n_state = r_found ? S_SPL1 : S_FIN;
                end else begin
                    if (!rd_busy && CW'(rd_sz) >= r_need &&
                        (!r_found || rd_sz < r_best_sz)) begin
                        n_found     = 1'b1;
                        n_best_pos  = r_pos;
                        n_best_sz   = rd_sz;
                        n_best_prev = rd_prev;
                    end
                    n_pos   = r_pos + rd_sz;
                    n_state = S_WRD;
                end
            end
            // mark the chosen block busy
            S_SPL1: begin
                mem_we    = 1'b1;
                mem_addr  = r_best_pos[AW-1:0];
                n_status  = STATUS_OK;
                if (r_best_sz > need_sz) begin
                    mem_wdata = {need_sz, 1'b1, r_best_prev};
                    n_state   = S_SPL2;
                end else begin
                    mem_wdata = {r_best_sz, 1'b1, r_best_prev};
                    n_state   = (nxt_pos < NGRAN_V) ? S_NRD : S_FIN;
                end
            end
            // free remainder after a split
            S_SPL2: begin
                mem_we    = 1'b1;
                mem_addr  = rem_pos[AW-1:0];
                mem_wdata = {r_best_sz - need_sz, 1'b0, 1'b1};
                n_state   = S_FIN;
            end
            // read-modify-write of the successor's previous-in-use mark
            S_NRD: begin
                mem_addr = nxt_pos[AW-1:0];
                n_state  = S_NWR;
            end
            S_NWR: begin
                mem_we    = 1'b1;
                mem_addr  = nxt_pos[AW-1:0];
                mem_wdata = {mem_rdata[HW-1:1], 1'b1};
                n_state   = S_FIN;
            end
            // load the result once the output register is free
            S_FIN: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_ofs    = (r_status == STATUS_OK) ? ofs_full[OFS_W-1:0] : '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
        end
        r_need       <= n_need;
        r_pos        <= n_pos;
        r_best_pos   <= n_best_pos;
        r_best_sz    <= n_best_sz;
        r_best_prev  <= n_best_prev;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_ofs    <= n_out_ofs;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_out_ofs, r_out_status};

endmodule

>>> design/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_port_checks
// Port-level checks for the best-fit block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfa_port_checks (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_tvalid,
    input logic                      o_s_tready,
    input logic [bfa_pkg::IN_W-1:0]  i_s_tdata,
    input logic                      o_m_tvalid,
    input logic                      i_m_tready,
    input logic [bfa_pkg::OUT_W-1:0] o_m_tdata
);
    import bfa_pkg::*;

    // one request at a time: no second item right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("item accepted while previous request still in work");

    // a failed result carries a zero offset
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[0] == STATUS_FAIL) |-> o_m_tdata[OFS_W:1] == '0)
        else $error("failed result with non-zero offset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed or dropped");

endmodule

bind best_fit_block_allocator bfa_port_checks u_bfa_port_checks (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
